### rtl/bas_pkg.sv
package bas_pkg;

   // field widths of the channels
   localparam int COORD_W    = 32;
   localparam int CFG_W      = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int PITCH_W    = 15;
   localparam int YAW_W      = 16;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_SPEED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY      = 8'd1;

   // angle unit widths: operand, cordic datapath, angle accumulator
   localparam int AW = 64;
   localparam int CW = 46;
   localparam int ZW = 27;
   localparam int CORDIC_STEPS = 16;

   typedef logic signed [AW-1:0] opnd_type;
   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [ZW-1:0] ang_type;

   // one cordic stage worth of state
   typedef struct packed {
      cord_type x;
      cord_type y;
      ang_type  z;
      logic     zero;
   } cordic_state_type;

   // angles in 2^-16 degree
   localparam ang_type DEG180 = ang_type'(11796480);
   localparam int ATAN_TAB [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   // output clamps in 1/128 degree
   localparam int PITCH_LIM = 11520;
   localparam int YAW_LIM   = 23040;

endpackage

### rtl/bas_if.sv
interface bas_req_if;
   import bas_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] from_x;
   logic signed [COORD_W-1:0] from_y;
   logic signed [COORD_W-1:0] from_z;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic signed [COORD_W-1:0] target_z;
   modport source (output valid, from_x, from_y, from_z, target_x, target_y, target_z,
                   input ready);
   modport sink (input valid, from_x, from_y, from_z, target_x, target_y, target_z,
                 output ready);
endinterface

interface bas_rsp_if;
   import bas_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      ok;
   logic signed [PITCH_W-1:0] pitch;
   logic signed [YAW_W-1:0]   yaw;
   modport source (output valid, ok, pitch, yaw, input ready);
   modport sink (input valid, ok, pitch, yaw, output ready);
endinterface

interface bas_csr_if;
   import bas_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/bas_delay.sv
module bas_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] line_ff [N];

   // shift line advancing with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[N-1];

endmodule

### rtl/bas_sqrt_cell.sv
module bas_sqrt_cell #(
   parameter int W  = 64,
   parameter int RW = 32,
   parameter int B  = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  rem_i,
   input  logic [RW-1:0] root_i,
   output logic [W-1:0]  rem_o,
   output logic [RW-1:0] root_o
);

   logic [W-1:0]  trial;
   logic [W-1:0]  rem_in;
   logic [W-1:0]  rem_ff;
   logic [RW-1:0] root_in;
   logic [RW-1:0] root_ff;

   // try to set root bit B: (2*root + 2^B) * 2^B against the remainder
   always_comb begin
      trial = (W'(root_i) << (B + 1)) | (W'(1) << (2 * B));
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = root_i | (RW'(1) << B);
      end else begin
         rem_in  = rem_i;
         root_in = root_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

### rtl/bas_cordic_cell.sv
module bas_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                      clock,
   input  logic                      en,
   input  bas_pkg::cordic_state_type st_i,
   output bas_pkg::cordic_state_type st_o
);
   import bas_pkg::*;

   cordic_state_type st_in;
   cordic_state_type st_ff;
   cord_type         xi;
   cord_type         yi;
   cord_type         xs;
   cord_type         ys;
   ang_type          za;

   // one vectoring micro-rotation toward y = 0
   always_comb begin
      xi = st_i.x;
      yi = st_i.y;
      xs = xi >>> STEP;
      ys = yi >>> STEP;
      za = ang_type'(ATAN_TAB[STEP]);
      st_in = st_i;
      if (yi > 0) begin
         st_in.x = xi + ys;
         st_in.y = yi - xs;
         st_in.z = st_i.z + za;
      end else begin
         st_in.x = xi - ys;
         st_in.y = yi + xs;
         st_in.z = st_i.z - za;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

### rtl/bas_angle.sv
module bas_angle #(
   parameter int LIM = 11520
) (
   input  logic                clock,
   input  logic                en,
   input  bas_pkg::opnd_type   x_i,
   input  bas_pkg::opnd_type   y_i,
   output logic signed [15:0]  ang_o
);
   import bas_pkg::*;

   localparam int NS = 6;

   opnd_type          nx_ff    [0:NS];
   opnd_type          ny_ff    [0:NS];
   logic [AW-1:0]     nm_ff    [0:NS];
   ang_type           nz_ff    [0:NS];
   logic              nzero_ff [0:NS];

   opnd_type          xa;
   opnd_type          ya;
   opnd_type          ay;
   ang_type           z0;
   logic              xneg;

   cordic_state_type  cst_init;
   cordic_state_type  cst_q [0:CORDIC_STEPS-1];

   logic signed [ZW:0] zr;
   logic signed [ZW:0] qv;
   logic signed [ZW:0] lim_p;
   logic signed [15:0] ang_in;
   logic signed [15:0] ang_ff;
   cordic_state_type   cst_last;

   // left half plane is turned by 180 degrees
   always_comb begin
      xneg = x_i < 0;
      xa   = xneg ? -x_i : x_i;
      ya   = xneg ? -y_i : y_i;
      ay   = (ya < 0) ? -ya : ya;
      if (xneg) begin
         z0 = (y_i >= 0) ? DEG180 : -DEG180;
      end else begin
         z0 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff[0]    <= xa;
         ny_ff[0]    <= ya;
         nm_ff[0]    <= (ay > xa) ? AW'(ay) : AW'(xa);
         nz_ff[0]    <= z0;
         nzero_ff[0] <= (x_i == 0) && (y_i == 0);
      end
   end

   // normalize the larger magnitude into [2^40, 2^41), one shift size a stage
   for (genvar j = 0; j < NS; j++) begin : g_norm
      localparam int K = 32 >> j;
      localparam bit CAN_R = (40 + K) <= 62;
      localparam logic [AW-1:0] HI_T = 64'd1 << ((40 + K) % 64);
      localparam logic [AW-1:0] LO_T = 64'd1 << (41 - K);
      logic go_r;
      logic go_l;

      assign go_r = CAN_R && (nm_ff[j] >= HI_T);
      assign go_l = !go_r && (nm_ff[j] < LO_T);

      always_ff @(posedge clock) begin
         if (en) begin
            if (go_r) begin
               nx_ff[j+1] <= nx_ff[j] >>> K;
               ny_ff[j+1] <= ny_ff[j] >>> K;
               nm_ff[j+1] <= nm_ff[j] >> K;
            end else if (go_l) begin
               nx_ff[j+1] <= nx_ff[j] <<< K;
               ny_ff[j+1] <= ny_ff[j] <<< K;
               nm_ff[j+1] <= nm_ff[j] << K;
            end else begin
               nx_ff[j+1] <= nx_ff[j];
               ny_ff[j+1] <= ny_ff[j];
               nm_ff[j+1] <= nm_ff[j];
            end
            nz_ff[j+1]    <= nz_ff[j];
            nzero_ff[j+1] <= nzero_ff[j];
         end
      end
   end

   // cordic row
   always_comb begin
      cst_init.x    = nx_ff[NS][CW-1:0];
      cst_init.y    = ny_ff[NS][CW-1:0];
      cst_init.z    = nz_ff[NS];
      cst_init.zero = nzero_ff[NS];
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      if (i == 0) begin : g_first
         bas_cordic_cell #(.STEP(i)) u_cell (
            .clock (clock),
            .en    (en),
            .st_i  (cst_init),
            .st_o  (cst_q[i])
         );
      end else begin : g_next
         bas_cordic_cell #(.STEP(i)) u_cell (
            .clock (clock),
            .en    (en),
            .st_i  (cst_q[i-1]),
            .st_o  (cst_q[i])
         );
      end
   end

   // round to 1/128 degree and clamp
   always_comb begin
      cst_last = cst_q[CORDIC_STEPS-1];
      lim_p    = (ZW+1)'(LIM);
      zr       = (ZW+1)'(cst_last.z) + (ZW+1)'(256);
      qv       = zr >>> 9;
      if (cst_last.zero) begin
         ang_in = '0;
      end else if (qv > lim_p) begin
         ang_in = 16'(lim_p);
      end else if (qv < -lim_p) begin
         ang_in = 16'(-lim_p);
      end else begin
         ang_in = 16'(qv);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign ang_o = ang_ff;

endmodule

### rtl/ballistic_aim_solver.sv
// a result reaches rsp after the front, sqrt rows, pitch cordic and output register
// throughput: one request per cycle outside stalls and settling, set by the fully pipelined
// sqrt and cordic rows; a stalled result holds the whole pipeline until it is taken
// reset is synchronous, clears valid bits and loads the register defaults;
// after reset and after any csr write, requests wait while derived products settle
module ballistic_aim_solver (
   input  logic  clock,
   input  logic  reset,
   bas_req_if.sink   req_ch,
   bas_rsp_if.source rsp_ch,
   bas_csr_if.sink   csr_ch
);
   import bas_pkg::*;

   localparam int NST = 86;
   localparam logic [CFG_W-1:0]     GRAVITY_RESET    = 24'd250880;
   localparam logic [1:0]           SETTLE           = 2'd3;

   function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] df;
      df = 33'(a) - 33'(b);
      if (df[32] != df[31]) begin
         sat_diff = df[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_diff = df[31:0];
      end
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   logic [NST-1:0]   vld_ff;
   logic             adv;
   logic [1:0]       settle_ff;

   logic [CFG_W-1:0] spd_ff;
   logic [CFG_W-1:0] grv_ff;
   logic [47:0]      v2_ff;
   logic [47:0]      g2_ff;
   logic [47:0]      ap0_ff;
   logic [47:0]      ap1_ff;
   logic [47:0]      ap2_ff;
   logic [47:0]      kp0_ff;
   logic [47:0]      kp1_ff;
   logic [95:0]      a_ff;
   logic [72:0]      k_ff;

   logic signed [31:0] dx1_ff;
   logic signed [31:0] dy1_ff;
   logic signed [31:0] dz1_ff;
   logic [63:0]        sqx2_ff;
   logic [63:0]        sqy2_ff;
   logic [31:0]        ah2_ff;
   logic               dzneg2_ff;
   logic [63:0]        s_sum;
   logic [63:0]        s3_ff;
   logic               small3_ff;
   logic [56:0]        cp0_3_ff;
   logic [56:0]        cp1_3_ff;
   logic [56:0]        cp2_3_ff;
   logic               dzneg3_ff;
   logic [55:0]        bp00_4_ff;
   logic [55:0]        bp01_4_ff;
   logic [55:0]        bp10_4_ff;
   logic [55:0]        bp11_4_ff;
   logic [105:0]       c4_ff;
   logic               dzneg4_ff;
   logic [111:0]       b5_ff;
   logic [105:0]       c5_ff;
   logic               dzneg5_ff;
   logic [111:0]       pos6_ff;
   logic [111:0]       neg6_ff;
   logic [111:0]       dsub;
   logic [105:0]       d7_ff;
   logic               oor7_ff;

   logic [63:0]        srem  [0:32];
   logic [31:0]        sroot [0:32];
   logic [105:0]       drem  [0:53];
   logic [52:0]        droot [0:53];

   logic [31:0]        d60;
   logic [31:0]        dz60;
   logic               small60;
   logic               oor60;
   logic [55:0]        den;
   opnd_type           num;
   opnd_type           px61_ff;
   opnd_type           py61_ff;
   logic               fail61_ff;
   opnd_type           yaw_x;
   opnd_type           yaw_y;
   logic signed [15:0] yaw25;
   logic [15:0]        yaw85;
   logic signed [15:0] pitch85;
   logic               fail85;
   logic               unset;

   logic               ok_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [YAW_W-1:0]   yaw_ff;

   // pipeline moves whenever the output register is free or being taken
   assign adv          = !vld_ff[NST-1] || rsp_ch.ready;
   assign req_ch.ready = adv && (settle_ff == '0);
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid && req_ch.ready};
      end
   end

   // config registers and settle counter
   always_ff @(posedge clock) begin
      if (reset) begin
         spd_ff    <= '0;
         grv_ff    <= GRAVITY_RESET;
         settle_ff <= SETTLE;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_LAUNCH_SPEED: spd_ff <= csr_ch.data[CFG_W-1:0];
               CSR_GRAVITY:      grv_ff <= csr_ch.data[CFG_W-1:0];
               default: ;
            endcase
            settle_ff <= SETTLE;
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // products that depend on config only: v^2, g^2, v^4, 2*g*v^2
   always_ff @(posedge clock) begin
      v2_ff  <= spd_ff * spd_ff;
      g2_ff  <= grv_ff * grv_ff;
      ap0_ff <= v2_ff[23:0] * v2_ff[23:0];
      ap1_ff <= v2_ff[23:0] * v2_ff[47:24];
      ap2_ff <= v2_ff[47:24] * v2_ff[47:24];
      kp0_ff <= grv_ff * v2_ff[23:0];
      kp1_ff <= grv_ff * v2_ff[47:24];
      a_ff   <= 96'(ap0_ff) + (96'(ap1_ff) << 25) + (96'(ap2_ff) << 48);
      k_ff   <= (73'(kp0_ff) + (73'(kp1_ff) << 24)) << 1;
   end

   // front: deltas, squares, discriminant terms
   assign s_sum = sqx2_ff + sqy2_ff;
   assign dsub  = pos6_ff - neg6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff    <= sat_diff(req_ch.target_x, req_ch.from_x);
         dy1_ff    <= sat_diff(req_ch.target_y, req_ch.from_y);
         dz1_ff    <= sat_diff(req_ch.target_z, req_ch.from_z);

         sqx2_ff   <= abs32(dx1_ff) * abs32(dx1_ff);
         sqy2_ff   <= abs32(dy1_ff) * abs32(dy1_ff);
         ah2_ff    <= abs32(dz1_ff);
         dzneg2_ff <= dz1_ff[31];

         s3_ff     <= s_sum;
         small3_ff <= s_sum < 64'd65536;
         cp0_3_ff  <= k_ff[24:0] * ah2_ff;
         cp1_3_ff  <= k_ff[49:25] * ah2_ff;
         cp2_3_ff  <= k_ff[72:50] * ah2_ff;
         dzneg3_ff <= dzneg2_ff;

         bp00_4_ff <= g2_ff[23:0] * s3_ff[31:0];
         bp01_4_ff <= g2_ff[23:0] * s3_ff[63:32];
         bp10_4_ff <= g2_ff[47:24] * s3_ff[31:0];
         bp11_4_ff <= g2_ff[47:24] * s3_ff[63:32];
         c4_ff     <= 106'(cp0_3_ff) + (106'(cp1_3_ff) << 25) + (106'(cp2_3_ff) << 50);
         dzneg4_ff <= dzneg3_ff;

         b5_ff     <= 112'(bp00_4_ff) + (112'(bp01_4_ff) << 32)
                      + (112'(bp10_4_ff) << 24) + (112'(bp11_4_ff) << 56);
         c5_ff     <= c4_ff;
         dzneg5_ff <= dzneg4_ff;

         pos6_ff   <= 112'(a_ff) + (dzneg5_ff ? 112'(c5_ff) : 112'd0);
         neg6_ff   <= b5_ff + (dzneg5_ff ? 112'd0 : 112'(c5_ff));

         d7_ff     <= dsub[105:0];
         oor7_ff   <= pos6_ff < neg6_ff;
      end
   end

   // horizontal distance: one root bit per cell
   assign srem[0]  = s3_ff;
   assign sroot[0] = '0;
   for (genvar i = 0; i < 32; i++) begin : g_dist
      bas_sqrt_cell #(.W(64), .RW(32), .B(31 - i)) u_cell (
         .clock  (clock),
         .en     (adv),
         .rem_i  (srem[i]),
         .root_i (sroot[i]),
         .rem_o  (srem[i+1]),
         .root_o (sroot[i+1])
      );
   end

   // square root of the discriminant
   assign drem[0]  = d7_ff;
   assign droot[0] = '0;
   for (genvar i = 0; i < 53; i++) begin : g_disc
      bas_sqrt_cell #(.W(106), .RW(53), .B(52 - i)) u_cell (
         .clock  (clock),
         .en     (adv),
         .rem_i  (drem[i]),
         .root_i (droot[i]),
         .rem_o  (drem[i+1]),
         .root_o (droot[i+1])
      );
   end

   // align side values with the discriminant root
   bas_delay #(.W(32), .N(25)) u_dly_d (
      .clock (clock), .en (adv), .d (sroot[32]), .q (d60)
   );
   bas_delay #(.W(32), .N(59)) u_dly_dz (
      .clock (clock), .en (adv), .d (dz1_ff), .q (dz60)
   );
   bas_delay #(.W(1), .N(57)) u_dly_small (
      .clock (clock), .en (adv), .d (small3_ff), .q (small60)
   );
   bas_delay #(.W(1), .N(53)) u_dly_oor (
      .clock (clock), .en (adv), .d (oor7_ff), .q (oor60)
   );

   // pitch operands: straight line for short range, low arc otherwise
   assign den = grv_ff * d60;
   assign num = $signed(64'(v2_ff)) - $signed(64'(droot[53]));

   always_ff @(posedge clock) begin
      if (adv) begin
         px61_ff   <= small60 ? opnd_type'(64'(d60)) : opnd_type'(64'(den));
         py61_ff   <= small60 ? opnd_type'({{32{dz60[31]}}, dz60}) : num;
         fail61_ff <= !small60 && oor60;
      end
   end

   bas_angle #(.LIM(PITCH_LIM)) u_pitch (
      .clock (clock),
      .en    (adv),
      .x_i   (px61_ff),
      .y_i   (py61_ff),
      .ang_o (pitch85)
   );

   // yaw runs early and waits in a delay line
   assign yaw_x = opnd_type'({{32{dx1_ff[31]}}, dx1_ff});
   assign yaw_y = opnd_type'({{32{dy1_ff[31]}}, dy1_ff});

   bas_angle #(.LIM(YAW_LIM)) u_yaw (
      .clock (clock),
      .en    (adv),
      .x_i   (yaw_x),
      .y_i   (yaw_y),
      .ang_o (yaw25)
   );

   bas_delay #(.W(16), .N(60)) u_dly_yaw (
      .clock (clock), .en (adv), .d (yaw25), .q (yaw85)
   );
   bas_delay #(.W(1), .N(24)) u_dly_fail (
      .clock (clock), .en (adv), .d (fail61_ff), .q (fail85)
   );

   // output register
   assign unset = (spd_ff == '0) || (grv_ff == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff    <= !unset && !fail85;
         pitch_ff <= (!unset && !fail85) ? pitch85[PITCH_W-1:0] : '0;
         yaw_ff   <= (!unset && !fail85) ? yaw85 : '0;
      end
   end

   assign rsp_ch.valid = vld_ff[NST-1];
   assign rsp_ch.ok    = ok_ff;
   assign rsp_ch.pitch = pitch_ff;
   assign rsp_ch.yaw   = yaw_ff;

`ifndef SYNTH
   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.ready) |=> !(req_ch.valid && req_ch.ready))
      else $error("request taken while config products settle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ok) |-> (rsp_ch.pitch == '0) && (rsp_ch.yaw == '0))
      else $error("failed solution carries nonzero angles");

   a_pitch_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.pitch <= 15'sd11520) && (rsp_ch.pitch >= -15'sd11520))
      else $error("pitch beyond clamp");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST-1] && !rsp_ch.ready) |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");
`endif

endmodule

### dv/ballistic_aim_solver_tb.sv
module ballistic_aim_solver_tb;
   import bas_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'd2;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic signed [COORD_W-1:0] fx, fy, fz, tx, ty, tz;
   } shot_type;

   typedef struct packed {
      logic                      ok;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
   } aim_type;

   logic clock;
   logic reset;
   bas_req_if req_ch ();
   bas_rsp_if rsp_ch ();
   bas_csr_if csr_ch ();

   ballistic_aim_solver dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   // model registers
   logic [CFG_W-1:0] speed_q;
   logic [CFG_W-1:0] grav_q;

   shot_type pending_shots[$];
   aim_type  expected_aims[$];
   int    failures;
   int    send_idle_pct;
   int    recv_stall_pct;

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // floor shift of a signed value
   function automatic longint fshr(longint v, int k);
      return v >>> k;
   endfunction

   // atan2 in 1/128 degree via vectoring cordic
   function automatic longint aim_angle(longint y, longint x, longint lim);
      longint z, m, q, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 11796480 : -11796480;
         x = -x;
         y = -y;
      end
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m >= (64'sd1 <<< 41)) begin
         x = fshr(x, 1); y = fshr(y, 1); m = m >>> 1;
      end
      while (m < (64'sd1 <<< 40)) begin
         x = x * 2; y = y * 2; m = m * 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = fshr(x, i);
         ys = fshr(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      q = fshr(z + 256, 9);
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q;
   endfunction

   function automatic logic [63:0] isqrt128(logic [127:0] n);
      logic [63:0] r, t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (n >= 128'(t) * 128'(t)) r = t;
      end
      return r;
   endfunction

   function automatic longint sat_delta(logic signed [31:0] a, logic signed [31:0] b);
      longint v;
      v = longint'(a) - longint'(b);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
   endfunction

   // firing solution for one request
   function automatic aim_type solve_aim(shot_type s);
      aim_type r;
      longint dx, dy, dz, yw, pt;
      logic [63:0] adx, ady, ssq, hdist, v2, adz;
      logic [127:0] pos, neg, cterm;
      longint num, den;
      r = '0;
      dx = sat_delta(s.tx, s.fx);
      dy = sat_delta(s.ty, s.fy);
      dz = sat_delta(s.tz, s.fz);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      ssq = adx * adx + ady * ady;
      hdist = isqrt128(128'(ssq));
      if (speed_q == 0 || grav_q == 0) return r;
      yw = aim_angle(dy, dx, YAW_LIM);
      if (ssq < 64'd65536) begin
         pt = aim_angle(dz, longint'(hdist), PITCH_LIM);
      end else begin
         v2 = 64'(speed_q) * 64'(speed_q);
         adz = dz < 0 ? -dz : dz;
         pos = 128'(v2) * 128'(v2);
         neg = 128'(64'(grav_q) * 64'(grav_q)) * 128'(ssq);
         cterm = 128'(v2) * 128'(adz) * 128'(2 * 64'(grav_q));
         if (dz < 0) pos = pos + cterm;
         else neg = neg + cterm;
         if (pos < neg) return r;
         num = longint'(v2) - longint'(isqrt128(pos - neg));
         den = longint'(64'(grav_q) * hdist);
         pt = aim_angle(num, den, PITCH_LIM);
      end
      r.ok = 1'b1;
      r.pitch = pt[PITCH_W-1:0];
      r.yaw = yw[YAW_W-1:0];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_shots.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            shot_type s;
            s = pending_shots.pop_front();
            expected_aims.push_back(solve_aim(s));
            req_ch.valid <= 1'b1;
            req_ch.from_x <= s.fx; req_ch.from_y <= s.fy; req_ch.from_z <= s.fz;
            req_ch.target_x <= s.tx; req_ch.target_y <= s.ty; req_ch.target_z <= s.tz;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result monitor and ready stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_aims.size() == 0) begin
               $display("%0t unexpected result ok=%0b pitch=%0d yaw=%0d", $time,
                        rsp_ch.ok, rsp_ch.pitch, rsp_ch.yaw);
               failures++;
            end else begin
               aim_type e;
               e = expected_aims.pop_front();
               if (rsp_ch.ok !== e.ok) begin
                  $display("%0t ok exp %0b got %0b", $time, e.ok, rsp_ch.ok);
                  failures++;
               end
               if (rsp_ch.pitch !== e.pitch) begin
                  $display("%0t pitch exp %0d got %0d", $time, e.pitch, rsp_ch.pitch);
                  failures++;
               end
               if (rsp_ch.yaw !== e.yaw) begin
                  $display("%0t yaw exp %0d got %0d", $time, e.yaw, rsp_ch.yaw);
                  failures++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_LAUNCH_SPEED) speed_q = value[CFG_W-1:0];
      else if (idx == CSR_GRAVITY) grav_q = value[CFG_W-1:0];
   endtask

   task automatic wait_drained();
      while (pending_shots.size() > 0 || expected_aims.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(8000)) - 4000) <<< 8;
         2: return $urandom_range(511) - 256;
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic shot_type rand_shot();
      shot_type s;
      s.fx = rand_coord(); s.fy = rand_coord(); s.fz = rand_coord();
      if ($urandom_range(3) == 0) begin
         s.tx = s.fx + $urandom_range(511) - 256;
         s.ty = s.fy + $urandom_range(511) - 256;
      end else begin
         s.tx = s.fx + rand_coord(); s.ty = s.fy + rand_coord();
      end
      s.tz = ($urandom_range(3) == 0) ? rand_coord() : s.fz + rand_coord();
      if ($urandom_range(15) == 0) begin
         s.tx = $urandom; s.ty = $urandom; s.tz = $urandom;
      end
      return s;
   endfunction

   function automatic shot_type mk(int fx, int fy, int fz, int tx, int ty, int tz);
      shot_type s;
      s.fx = fx; s.fy = fy; s.fz = fz; s.tx = tx; s.ty = ty; s.tz = tz;
      return s;
   endfunction

   task automatic push_directed();
      pending_shots.push_back(mk(0, 0, 0, 0, 0, 0));
      pending_shots.push_back(mk(0, 0, 0, 100 << 8, 0, 0));
      pending_shots.push_back(mk(0, 0, 0, -(100 << 8), 0, 0));
      pending_shots.push_back(mk(0, 0, 0, 0, 100 << 8, 10 << 8));
      pending_shots.push_back(mk(0, 0, 0, 0, -(100 << 8), -(10 << 8)));
      pending_shots.push_back(mk(0, 0, 0, 100, 50, 1000));
      pending_shots.push_back(mk(0, 0, 0, 0, 0, -5000));
      pending_shots.push_back(mk(0, 0, 0, 255, 0, 0));
      pending_shots.push_back(mk(0, 0, 0, 256, 0, 0));
      pending_shots.push_back(mk(0, 0, 0, 5000 << 8, 0, 0));
      pending_shots.push_back(mk(0, 0, 0, 30 << 8, 30 << 8, 2000 << 8));
      pending_shots.push_back(mk(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_shots.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                 -32'sh80000000, -32'sh80000000, -32'sh80000000));
      pending_shots.push_back(mk(0, 0, 0, -1, -1, -1));
      pending_shots.push_back(mk(-1, 0, 0, 0, -32'sh80000000, 0));
   endtask

   task automatic run_phase(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) pending_shots.push_back(rand_shot());
      wait_drained();
   endtask

   // stimulus
   initial begin
      failures = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      speed_q = '0;
      grav_q = 24'd250880;
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // speed unset after reset
      push_directed();
      wait_drained();
      write_reg(CSR_LAUNCH_SPEED, 32'd500 << 8);
      write_reg(CSR_UNUSED, 32'hdeadbeef);
      push_directed();
      wait_drained();
      run_phase(250, 0, 0);
      write_reg(CSR_LAUNCH_SPEED, 32'hff123456);
      write_reg(CSR_GRAVITY, 32'd1);
      run_phase(200, 51, 0);
      write_reg(CSR_LAUNCH_SPEED, 32'd60 << 8);
      write_reg(CSR_GRAVITY, 32'hffffff);
      run_phase(200, 0, 51);
      write_reg(CSR_GRAVITY, 32'd0);
      run_phase(80, 33, 33);
      write_reg(CSR_GRAVITY, 32'd9 << 8);
      write_reg(CSR_LAUNCH_SPEED, 32'd1);
      run_phase(100, 0, 0);
      write_reg(CSR_LAUNCH_SPEED, $urandom_range(24'hffffff));
      write_reg(CSR_GRAVITY, $urandom_range(24'hffffff));
      run_phase(200, 33, 33);
      write_reg(CSR_LAUNCH_SPEED, 32'd2000 << 8);
      write_reg(CSR_GRAVITY, 32'd980 << 8 >> 2);
      run_phase(300, 33, 33);

      if (failures == 0) begin
         $display("ballistic_aim_solver_tb OK");
      end else begin
         $display("ballistic_aim_solver_tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("ballistic_aim_solver_tb NOT OK");
      $finish;
   end

endmodule
